// ===== hw/rtl/sirt_pkg.sv =====
package sirt_pkg;

  localparam int unsigned TableDepthDef = 64;

  typedef enum logic {
    ReqInsert = 1'b0,
    ReqClear  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StOverlap = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] class_id;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  slot;
    logic [6:0]  entry_count;
    logic [31:0] clash_start;
    logic [31:0] clash_end;
  } rsp_t;

  typedef struct packed {
    logic [15:0] class_id;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } entry_t;

endpackage

// ===== hw/rtl/sirt_if.sv =====
interface sirt_req_if;
  import sirt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sirt_rsp_if;
  import sirt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sorted_interval_reservation_table_core.sv =====
// Sorted interval reservation table.
// req_i carries one request per transaction: insert an interval with a class
// tag, or clear the table. rsp_o returns exactly one result per request:
// status, sorted slot, entry count and the bounds of a clashing entry.
// One request is worked at a time; req_i.ready is high only while idle.
// A single memory read port serves both the ordered scan and the shift, so
// each visited entry takes an address step, then a compare or move step.
// Insert with n stored entries landing at slot p: scan slots 0 to p (only
// up to p-1 if p equals n), move entries p to n-1 up by one slot, write the
// new entry at p, then load the result register. Overlap at slot p: scan
// slots 0 to p, then load the result. Clear and full rejection load it directly.
// Reset empties the table at once; stored data is not cleared and is never
// read before it is written. No sweep after reset.
// When the receiver stalls, the result waits in the output register; the
// next request is still taken and worked, and its result waits in a holding
// register until the output register frees.
module sorted_interval_reservation_table_core #(
  parameter int unsigned TABLE_DEPTH = sirt_pkg::TableDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sirt_req_if.sink        req_i,
  sirt_rsp_if.source      rsp_o
);
  import sirt_pkg::*;

  localparam int unsigned AddrW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CountW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [6:0] {
    Idle    = 7'b0000001,
    ScanRd  = 7'b0000010,
    ScanCmp = 7'b0000100,
    ShiftRd = 7'b0001000,
    ShiftWr = 7'b0010000,
    Insert  = 7'b0100000,
    Resp    = 7'b1000000
  } state_e;

  state_e              state_d, state_q;
  logic [CountW-1:0]   count_d, count_q;
  logic [CountW-1:0]   pos_d, pos_q;
  logic [CountW-1:0]   k_d, k_q;
  req_t                cur_d, cur_q;
  rsp_t                res_d, res_q;
  rsp_t                out_d, out_q;
  logic                out_valid_d, out_valid_q;

  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic [AddrW-1:0]    mem_raddr;
  entry_t              mem_rdata;

  logic [CountW-1:0]   pos_inc;
  logic [CountW-1:0]   k_dec;
  logic [CountW-1:0]   count_inc;
  logic [CountW+6:0]   pos_ext;
  logic [CountW+6:0]   count_ext;
  logic [CountW+6:0]   count_inc_ext;
  logic                out_free;

  sirt_store #(
    .Depth (TABLE_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign pos_inc       = pos_q + CountW'(1);
  assign k_dec         = k_q - CountW'(1);
  assign count_inc     = count_q + CountW'(1);
  assign pos_ext       = {7'd0, pos_q};
  assign count_ext     = {7'd0, count_q};
  assign count_inc_ext = {7'd0, count_inc};
  assign out_free      = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == Idle);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    k_d         = k_q;
    cur_d       = cur_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = k_q[AddrW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = pos_q[AddrW-1:0];

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      Idle: begin
        if (req_i.valid) begin
          cur_d = req_i.data;
          pos_d = '0;
          k_d   = count_q;
          res_d = '{status: StOk, slot: 7'd0, entry_count: count_ext[6:0],
                    clash_start: 32'd0, clash_end: 32'd0};
          if (req_i.data.req_type == ReqClear) begin
            count_d           = '0;
            res_d.entry_count = 7'd0;
            state_d           = Resp;
          end else if (count_q >= CountW'(TABLE_DEPTH)) begin
            res_d.status = StFull;
            state_d      = Resp;
          end else if (count_q == '0) begin
            state_d = Insert;
          end else begin
            state_d = ScanRd;
          end
        end
      end
      ScanRd: begin
        state_d = ScanCmp;
      end
      ScanCmp: begin
        if (cur_q.start_time >= mem_rdata.end_time) begin
          pos_d = pos_inc;
          if (pos_inc == count_q) begin
            state_d = Insert;
          end else begin
            state_d = ScanRd;
          end
        end else if (cur_q.end_time <= mem_rdata.start_time) begin
          state_d = (k_q == pos_q) ? Insert : ShiftRd;
        end else begin
          res_d.status      = StOverlap;
          res_d.slot        = pos_ext[6:0];
          res_d.clash_start = mem_rdata.start_time;
          res_d.clash_end   = mem_rdata.end_time;
          state_d           = Resp;
        end
      end
      ShiftRd: begin
        mem_raddr = k_dec[AddrW-1:0];
        state_d   = ShiftWr;
      end
      ShiftWr: begin
        mem_we  = 1'b1;
        k_d     = k_dec;
        state_d = (k_dec == pos_q) ? Insert : ShiftRd;
      end
      Insert: begin
        mem_we            = 1'b1;
        mem_waddr         = pos_q[AddrW-1:0];
        mem_wdata         = '{class_id: cur_q.class_id, start_time: cur_q.start_time,
                              end_time: cur_q.end_time};
        count_d           = count_inc;
        res_d.slot        = pos_ext[6:0];
        res_d.entry_count = count_inc_ext[6:0];
        state_d           = Resp;
      end
      Resp: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = Idle;
        end
      end
      default: begin
        state_d = Idle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    k_q   <= k_d;
    cur_q <= cur_d;
    res_q <= res_d;
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_shift_above_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ShiftWr) |-> (k_q > pos_q))
    else $error("shift reached below insert slot");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Insert) |=> (count_q == $past(count_inc)))
    else $error("insert did not grow the table by one");

  a_resp_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Resp && out_free) |=> (out_valid_q && state_q == Idle))
    else $error("result not moved to output register");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ScanRd || state_q == ScanCmp) |-> (pos_q < count_q))
    else $error("scan position beyond stored entries");
`endif

endmodule

// ===== hw/rtl/sirt_store.sv =====
module sirt_store #(
  parameter int unsigned Depth = sirt_pkg::TableDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  sirt_pkg::entry_t  wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output sirt_pkg::entry_t  rdata_o
);
  import sirt_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
